>>> src/hfir_pkg.sv
package hfir_pkg;

  // default build options
  localparam int TAPS_DEFAULT  = 63;
  localparam int DELAY_DEFAULT = 31;

  // datapath widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;   // signed Q1.16, magnitude stays below 2^17
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 40;   // covers the longest filter with headroom

  // fixed-point constants for the coefficient build
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // controller to datapath
  typedef struct packed {
    logic start;   // word taken: write history, clear accumulator
    logic issue;   // read one history entry for the current tap
    logic load;    // move the finished result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;    // reads still in flight through the mac pipeline
  } sts_t;

endpackage

>>> src/hilbert_fir_real_to_iq.sv
// real to iq converter: hamming-windowed hilbert fir plus matched delay
//
// input channel s_axis: one signed q15 sample per word
// output channel m_axis: one iq word per input word, real part in the low
//   half (input delayed by DELAY samples), imag part in the high half
//   (hilbert fir sum, rounded half up and saturated to 16 bits)
//
// one word is processed at a time; a single multiply-accumulate unit walks
// the TAPS history entries, one tap per cycle, out of a one-port history ram
// the result is loaded into the output register once the tap sweep and the
//   mac pipeline drain are done; s_axis_tready comes back in the same cycle
//   that m_axis_tvalid rises, so no new word is taken before the last is loaded
// the output register holds a finished word while the next one is computed;
//   if the receiver stalls and that register is still full at the end of
//   the next computation, the block waits there and keeps s_axis_tready low
// reset clears the history (per-entry valid bits), the write position and
//   all handshake state; unwritten history entries read as zero
module hilbert_fir_real_to_iq #(
  parameter int TAPS  = hfir_pkg::TAPS_DEFAULT,   // filter length, 7 to 255
  parameter int DELAY = hfir_pkg::DELAY_DEFAULT   // filter centre and real delay
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata     // [15:0] real_part, [31:16] imag_part
);

  localparam int IDX_W = $clog2(TAPS);

  hfir_pkg::cmd_t   cmd;      // controller commands
  hfir_pkg::sts_t   sts;      // datapath status
  logic [IDX_W-1:0] tap;      // tap index being read

  logic signed [hfir_pkg::SAMPLE_W-1:0] real_part;
  logic signed [hfir_pkg::SAMPLE_W-1:0] imag_part;

  // sequencer: accept, tap sweep, pipeline drain, output hand-off
  hfir_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd),
    .tap           (tap),
    .sts           (sts)
  );

  // history ram, coefficient rom, mac pipeline and output register
  hfir_dpath #(
    .TAPS  (TAPS),
    .DELAY (DELAY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .tap       (tap),
    .sample    (s_axis_tdata),
    .sts       (sts),
    .real_part (real_part),
    .imag_part (imag_part)
  );

  // pack the iq word, real in the low half
  assign m_axis_tdata = {imag_part, real_part};

endmodule

>>> src/hfir_dpath.sv
module hfir_dpath #(
  parameter int TAPS  = hfir_pkg::TAPS_DEFAULT,
  parameter int DELAY = hfir_pkg::DELAY_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hfir_pkg::cmd_t                        cmd,
  input  logic [$clog2(TAPS)-1:0]               tap,
  input  logic signed [hfir_pkg::SAMPLE_W-1:0]  sample,
  output hfir_pkg::sts_t                        sts,
  output logic signed [hfir_pkg::SAMPLE_W-1:0]  real_part,
  output logic signed [hfir_pkg::SAMPLE_W-1:0]  imag_part
);

  localparam int IDX_W   = $clog2(TAPS);
  localparam int SPAN    = (TAPS > 1) ? TAPS - 1 : 1;
  localparam int DLY_IDX = DELAY % TAPS;
  localparam int SW      = hfir_pkg::SAMPLE_W;
  localparam int CW      = hfir_pkg::COEF_W;
  localparam int PW      = hfir_pkg::PROD_W;
  localparam int AW      = hfir_pkg::ACC_W;

  // coefficient table, built at elaboration
  logic signed [CW-1:0] coef [TAPS];

  for (genvar gk = 0; gk < TAPS; gk++) begin : g_coef
    localparam longint unsigned NUM0 = longint'(gk) % longint'(SPAN);
    localparam longint unsigned NUM1 = (2 * NUM0 > SPAN) ? SPAN - NUM0 : NUM0;
    localparam longint unsigned Q0   = 2 * NUM1;
    localparam bit              NEG  = (2 * Q0 > SPAN);
    localparam longint unsigned QA   = NEG ? SPAN - Q0 : Q0;
    localparam longint unsigned Y    = (hfir_pkg::PI_Q30 * QA) / SPAN;
    // taylor terms, truncated after each multiply and each divide
    localparam longint unsigned T1 = ((((hfir_pkg::ONE_Q30 * Y) >> 30) * Y) >> 30) / 2;
    localparam longint unsigned T2 = ((((T1 * Y) >> 30) * Y) >> 30) / 12;
    localparam longint unsigned T3 = ((((T2 * Y) >> 30) * Y) >> 30) / 30;
    localparam longint unsigned T4 = ((((T3 * Y) >> 30) * Y) >> 30) / 56;
    localparam longint unsigned T5 = ((((T4 * Y) >> 30) * Y) >> 30) / 90;
    localparam longint unsigned T6 = ((((T5 * Y) >> 30) * Y) >> 30) / 132;
    localparam longint unsigned T7 = ((((T6 * Y) >> 30) * Y) >> 30) / 182;
    localparam longint unsigned T8 = ((((T7 * Y) >> 30) * Y) >> 30) / 240;
    localparam longint unsigned T9 = ((((T8 * Y) >> 30) * Y) >> 30) / 306;
    localparam longint SUM = longint'(hfir_pkg::ONE_Q30) - longint'(T1) + longint'(T2)
                           - longint'(T3) + longint'(T4) - longint'(T5) + longint'(T6)
                           - longint'(T7) + longint'(T8) - longint'(T9);
    localparam longint COSV = NEG ? -SUM : SUM;
    localparam longint WNUM = 54 * longint'(hfir_pkg::ONE_Q30) - 46 * COSV;
    localparam int     N    = gk - DELAY;
    localparam longint unsigned MAG   = (N < 0) ? longint'(-N) : longint'(N);
    localparam longint unsigned NUMER = longint'(131072) * WNUM;
    localparam longint unsigned DENOM = 100 * hfir_pkg::PI_Q30 * ((MAG == 0) ? 1 : MAG);
    localparam longint unsigned R     = (NUMER + DENOM / 2) / DENOM;
    localparam longint CVAL = (MAG % 2 == 1) ? ((N < 0) ? -longint'(R) : longint'(R)) : 0;
    assign coef[gk] = CW'(CVAL);
  end

  // sample history with per-entry valid bits
  logic signed [SW-1:0] hist_mem [TAPS];
  logic [TAPS-1:0]      hist_vld;
  logic [IDX_W-1:0]     pos;
  logic [IDX_W-1:0]     rd_idx;

  // mac pipeline
  logic signed [SW-1:0] rd_data;
  logic                 rd_vld;
  logic [IDX_W-1:0]     k1;
  logic                 p1_en;
  logic signed [SW-1:0] samp;
  logic signed [PW-1:0] prod;
  logic                 p2_en;
  logic signed [AW-1:0] acc;
  logic signed [SW-1:0] dly_samp;

  // rounding and saturation
  logic signed [AW-1:0]    rnd;
  logic signed [AW-17:0]   rq;
  logic signed [SW-1:0]    imag_sat;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hist_mem[pos] <= sample;
    end
    if (cmd.issue) begin
      rd_data <= hist_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      pos      <= '0;
      p1_en    <= 1'b0;
      p2_en    <= 1'b0;
    end else begin
      p1_en <= cmd.issue;
      p2_en <= p1_en;
      if (cmd.start) begin
        hist_vld[pos] <= 1'b1;
        pos <= (pos == IDX_W'(TAPS - 1)) ? '0 : pos + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_idx <= pos;
      acc    <= '0;
    end else begin
      if (cmd.issue) begin
        rd_idx <= (rd_idx == '0) ? IDX_W'(TAPS - 1) : rd_idx - IDX_W'(1);
      end
      if (p2_en) begin
        acc <= acc + AW'(prod);
      end
    end
    if (cmd.issue) begin
      rd_vld <= hist_vld[rd_idx];
      k1     <= tap;
    end
    if (p1_en) begin
      prod <= PW'(coef[k1]) * PW'(samp);
      if (k1 == IDX_W'(DLY_IDX)) begin
        dly_samp <= samp;
      end
    end
    if (cmd.load) begin
      real_part <= dly_samp;
      imag_part <= imag_sat;
    end
  end

  assign samp = rd_vld ? rd_data : '0;

  // round half up, then clamp to 16 bits
  assign rnd = acc + AW'(32'sd32768);
  assign rq  = rnd[AW-1:16];

  always_comb begin
    if ((&rq[AW-17:SW-1]) || !(|rq[AW-17:SW-1])) begin
      imag_sat = rq[SW-1:0];
    end else if (rq[AW-17]) begin
      imag_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      imag_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  assign sts.busy = p1_en | p2_en;

endmodule

>>> src/hfir_ctrl.sv
module hfir_ctrl #(
  parameter int TAPS = hfir_pkg::TAPS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output hfir_pkg::cmd_t          cmd,
  output logic [$clog2(TAPS)-1:0] tap,
  input  hfir_pkg::sts_t          sts
);

  localparam int IDX_W = $clog2(TAPS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // no word is taken while reset is held
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign cmd.start = s_axis_tvalid && s_axis_tready;
  assign cmd.issue = (state == ST_ISSUE);
  assign cmd.load  = (state == ST_DRAIN) && !sts.busy && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (tap == IDX_W'(TAPS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tap           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        tap <= '0;
      end else if (cmd.issue) begin
        tap <= tap + IDX_W'(1);
      end
      if (cmd.load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // build of the block under test
  localparam int TAPS  = hfir_pkg::TAPS_DEFAULT;
  localparam int DELAY = hfir_pkg::DELAY_DEFAULT;

  // fixed-point constants for the coefficient set
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  localparam int N_RANDOM   = 480;
  localparam int HOLD_LEN   = 1000;   // long receiver hold-off
  localparam int HOLD_AT    = 120;    // random word that triggers the hold-off
  localparam int QUIET_FROM = 250;    // stretch with no idling on either side
  localparam int QUIET_TO   = 400;
  localparam int WATCHDOG   = 4000;   // cycles with no word moved on either side

  // one iq word as it sits on m_axis_tdata, imag in the high half
  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } iq_word_t;

  // directed row: input sample and the real part that must come back
  typedef struct packed {
    logic [15:0]        smp;
    logic signed [15:0] re;
  } stim_row_t;

  localparam int N_DIR = 20;

  // the delay line is still full of cleared entries for all of these rows,
  // so the real part reads back as zero; imag comes from the predictor
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    '{16'h0000, 16'sd0},   // nothing but zeros
    '{16'h7fff, 16'sd0},   // positive full-scale impulse
    '{16'h0000, 16'sd0},
    '{16'h0000, 16'sd0},
    '{16'h0000, 16'sd0},
    '{16'h0000, 16'sd0},
    '{16'h8000, 16'sd0},   // negative full scale
    '{16'h0000, 16'sd0},
    '{16'h0000, 16'sd0},
    '{16'h0001, 16'sd0},   // smallest magnitudes
    '{16'hffff, 16'sd0},
    '{16'h5555, 16'sd0},   // alternating bit patterns
    '{16'haaaa, 16'sd0},
    '{16'h7fff, 16'sd0},   // full-scale square wave
    '{16'h8000, 16'sd0},
    '{16'h7fff, 16'sd0},
    '{16'h8000, 16'sd0},
    '{16'h00ff, 16'sd0},
    '{16'hff00, 16'sd0},
    '{16'h0000, 16'sd0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;    // [15:0] sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [15:0] real_part, [31:16] imag_part

  // predictor state
  longint             hilbert_coef [TAPS];
  logic signed [15:0] sample_hist  [TAPS];
  int                 hist_wr;

  iq_word_t iq_pending [$];          // expected iq words, oldest first
  int       mismatches   = 0;
  int       quiet_cycles = 0;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;

  hilbert_fir_real_to_iq #(
    .TAPS  (TAPS),
    .DELAY (DELAY)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // cos(2*pi*num/den) in q30: fold the angle into the first quadrant,
  // then a taylor series through x^18 with truncation after every step
  function automatic longint cos_q30(longint unsigned num, longint unsigned den);
    longint unsigned q, ang, term;
    longint          sum;
    bit              flip;
    num  = num % den;
    flip = 1'b0;
    if (2 * num > den) begin
      num = den - num;
    end
    q = 2 * num;
    if (2 * q > den) begin
      q    = den - q;
      flip = 1'b1;
    end
    ang  = (PI_Q30 * q) / den;
    sum  = ONE_Q30;
    term = ONE_Q30;
    for (int i = 1; i <= 9; i++) begin
      term = (term * ang) >> 30;
      term = (term * ang) >> 30;
      term = term / longint'((2 * i) * (2 * i - 1));
      if (i % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return flip ? -sum : sum;
  endfunction

  // hamming-windowed hilbert taps, q1.16, rounded half away from zero
  function automatic void build_hilbert_coef();
    longint          offs, wnum;
    longint unsigned mag, numer, denom, r;
    for (int k = 0; k < TAPS; k++) begin
      offs = k - DELAY;
      mag  = (offs < 0) ? -offs : offs;
      if (mag == 0 || mag % 2 == 0) begin
        hilbert_coef[k] = 0;
      end else begin
        wnum  = 54 * ONE_Q30 - 46 * cos_q30(k, (TAPS > 1) ? TAPS - 1 : 1);
        numer = 64'd131072 * longint'(wnum);
        denom = 64'd100 * PI_Q30 * mag;
        r     = (numer + denom / 2) / denom;
        hilbert_coef[k] = (offs < 0) ? -longint'(r) : longint'(r);
      end
    end
  endfunction

  // one sample into the history, one iq word out
  function automatic iq_word_t iq_from_sample(logic signed [15:0] smp);
    longint   acc, rnd;
    int       idx;
    iq_word_t res;
    sample_hist[hist_wr] = smp;
    acc = 0;
    idx = hist_wr;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + hilbert_coef[k] * longint'(sample_hist[idx]);
      idx = (idx == 0) ? TAPS - 1 : idx - 1;
    end
    // round half up: floor of (acc + half lsb) in q15
    rnd = (acc + 32768) >>> 16;
    if (rnd > 32767) begin
      rnd = 32767;
    end else if (rnd < -32768) begin
      rnd = -32768;
    end
    res.im  = rnd[15:0];
    res.re  = sample_hist[(hist_wr + TAPS - DELAY % TAPS) % TAPS];
    hist_wr = (hist_wr + 1) % TAPS;
    return res;
  endfunction

  // offer one word on s_axis, optionally after an idle gap, and log the
  // expected iq word once the block takes it
  task automatic push_sample(input logic [15:0] smp, input bit re_known,
                             input logic signed [15:0] re_typed);
    int       gap;
    iq_word_t want;
    gap = (tx_idle_on && $urandom_range(99) < 12) ? $urandom_range(1, 2 * TAPS) : 0;
    @(negedge clk);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk); while (!s_axis_tready);
    want = iq_from_sample(smp);
    if (re_known) begin
      want.re = re_typed;
    end
    iq_pending.push_back(want);
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        for (int i = 0; i < HOLD_LEN; i++) begin
          m_axis_tready <= 1'b0;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 12);
      end
    end
  end

  // output check, sampled at the rising edge
  always @(posedge clk) begin
    iq_word_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (iq_pending.size() == 0) begin
        mismatches++;
        $display("%0t: iq word with nothing expected: re=%0d im=%0d",
                 $realtime, got.re, got.im);
      end else begin
        want = iq_pending.pop_front();
        if (got.re !== want.re) begin
          mismatches++;
          $display("%0t: real_part expected %0d actual %0d", $realtime, want.re, got.re);
        end
        if (got.im !== want.im) begin
          mismatches++;
          $display("%0t: imag_part expected %0d actual %0d", $realtime, want.im, got.im);
        end
      end
    end
  end

  // watchdog on cycles in which no word moves on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int          sent, kind, seg_len, half;
    logic [15:0] smp, lvl;
    build_hilbert_coef();
    for (int k = 0; k < TAPS; k++) begin
      sample_hist[k] = '0;
    end
    hist_wr = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows straight after reset
    for (int r = 0; r < N_DIR; r++) begin
      push_sample(DIR_ROWS[r].smp, 1'b1, DIR_ROWS[r].re);
    end

    // random segments: noise, full-scale or random steps, square waves, small values;
    // steps and squares drive the filter into saturation both ways
    sent = 0;
    while (sent < N_RANDOM) begin
      kind    = $urandom_range(3);
      seg_len = $urandom_range(10, 80);
      half    = $urandom_range(1, 8);
      case ($urandom_range(2))
        0:       lvl = 16'h7fff;
        1:       lvl = 16'h8000;
        default: lvl = 16'($urandom);
      endcase
      for (int j = 0; j < seg_len && sent < N_RANDOM; j++) begin
        case (kind)
          0:       smp = 16'($urandom);
          1:       smp = lvl;
          2:       smp = ((j / half) % 2 == 1) ? 16'h8000 : 16'h7fff;
          default: smp = 16'($signed($urandom_range(0, 15)) - 8);
        endcase
        push_sample(smp, 1'b0, 16'sd0);
        sent++;
        if (sent == HOLD_AT) begin
          hold_req = 1'b1;   // receiver stops while words keep coming
        end
        tx_idle_on = !(sent >= QUIET_FROM && sent < QUIET_TO);
        rx_idle_on = tx_idle_on;
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // drain, then give the block its latency to show any stray word
    while (iq_pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAPS + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
